FILE: sv/efpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpg_pkg: shared types and constants
// Coordinate widths, register indexes, queue depths and the request records
// passed between the scan front end and the ellipse test back end.
// ----------------------------------------------------------------------------
package efpg_pkg;

    localparam int COORD_BITS  = 10;
    localparam int COLOR_BITS  = 16;
    localparam int AXIS_BITS   = COORD_BITS - 1;
    localparam int SQ_AXIS     = 2 * AXIS_BITS;
    localparam int SQ_DELTA    = 2 * COORD_BITS;
    localparam int PROD_BITS   = SQ_DELTA + SQ_AXIS;
    localparam int AREA_BITS   = 2 * SQ_AXIS;
    localparam int CFG_IDX_BITS = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_ABITS = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_ABITS   = $clog2(OUT_DEPTH);

    localparam logic [COLOR_BITS-1:0] WHITE_565 = 16'hFFFF;

    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_COLOR = 3'd4;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_box;

    // one classified pixel request from the scan front end
    typedef struct packed {
        t_coord col;
        t_coord row;
        t_coord dx;
        t_coord dy;
        logic   last;
    } t_item;

    typedef struct packed {
        logic [COLOR_BITS-1:0] value;
        t_coord                col;
        t_coord                row;
        logic                  last;
    } t_pix;

    // an end edge below its start edge counts as the start edge
    function automatic t_coord clamp_edge(input t_coord lo, input t_coord hi);
        return (hi < lo) ? lo : hi;
    endfunction

    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        return (a >= b) ? t_coord'(a - b) : t_coord'(b - a);
    endfunction

endpackage

FILE: sv/efpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpg_front: scan position and pixel classification
// Holds the scan counter, applies restart, flags the row end and the last
// pixel of the box, and computes the distances from the ellipse center.
// ----------------------------------------------------------------------------
module efpg_front import efpg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_box  i_box,
    input  logic  i_accept,
    input  logic  i_restart,
    output t_item o_item
);

    t_coord r_scan_col, n_scan_col;
    t_coord r_scan_row, n_scan_row;

    t_coord eff_right, eff_bottom, col, row, cx, cy;
    logic   row_end, last;
    logic [COORD_BITS:0] sum_x, sum_y;

    always_comb begin
        eff_right  = clamp_edge(i_box.left, i_box.right);
        eff_bottom = clamp_edge(i_box.top, i_box.bottom);
        col = i_restart ? i_box.left : r_scan_col;
        row = i_restart ? i_box.top  : r_scan_row;
        sum_x = {1'b0, i_box.left} + {1'b0, eff_right};
        sum_y = {1'b0, i_box.top}  + {1'b0, eff_bottom};
        cx = sum_x[COORD_BITS:1];
        cy = sum_y[COORD_BITS:1];
        row_end = (col >= eff_right);
        last    = row_end && (row >= eff_bottom);

        o_item.col  = col;
        o_item.row  = row;
        o_item.dx   = abs_diff(col, cx);
        o_item.dy   = abs_diff(row, cy);
        o_item.last = last;

        if (last) begin
            n_scan_col = i_box.left;
            n_scan_row = i_box.top;
        end else if (row_end) begin
            n_scan_col = i_box.left;
            n_scan_row = row + t_coord'(1);
        end else begin
            n_scan_col = col + t_coord'(1);
            n_scan_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col <= '0;
            r_scan_row <= '0;
        end else if (i_accept) begin
            r_scan_col <= n_scan_col;
            r_scan_row <= n_scan_row;
        end
    end

endmodule

FILE: sv/efpg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpg_queue: request queue between front and back end
// Small first-in first-out buffer of classified pixel requests.
// ----------------------------------------------------------------------------
module efpg_queue import efpg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    t_item r_mem [QUEUE_DEPTH];
    logic [QUEUE_ABITS-1:0] r_wr, r_rd;
    logic [QUEUE_ABITS:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_ABITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_ABITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_ABITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_ABITS+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QUEUE_ABITS+1)'(1);
            end
        end
    end

endmodule

FILE: sv/efpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpg_back: ellipse inside test and result buffer
// Two-stage multiply pipeline for dx^2*B + dy^2*A < A*B, followed by the
// result queue. Requests are taken only when the result queue has room for
// everything already in flight.
// ----------------------------------------------------------------------------
module efpg_back import efpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_box                  i_box,
    input  logic [COLOR_BITS-1:0] i_fill_color,
    input  logic                  i_req_valid,
    input  t_item                 i_req,
    output logic                  o_req_pop,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_pix                  o_pix
);

    // geometry, recomputed every cycle from the box registers
    t_coord eff_right, eff_bottom;
    t_coord span_x, span_y;
    logic [AXIS_BITS-1:0] ax, ay;
    logic [SQ_AXIS-1:0]   r_aa, r_bb;
    logic [AREA_BITS-1:0] r_ab;
    logic                 r_zero;

    always_comb begin
        eff_right  = clamp_edge(i_box.left, i_box.right);
        eff_bottom = clamp_edge(i_box.top, i_box.bottom);
        span_x = eff_right - i_box.left;
        span_y = eff_bottom - i_box.top;
        ax = span_x[COORD_BITS-1:1];
        ay = span_y[COORD_BITS-1:1];
    end

    always_ff @(posedge i_clk) begin
        r_aa   <= SQ_AXIS'(ax) * SQ_AXIS'(ax);
        r_bb   <= SQ_AXIS'(ay) * SQ_AXIS'(ay);
        r_zero <= (ax == '0) || (ay == '0);
        r_ab   <= AREA_BITS'(r_aa) * AREA_BITS'(r_bb);
    end

    // multiply pipeline
    logic                 r_v1, r_v2;
    logic [SQ_DELTA-1:0]  r_dx2, r_dy2;
    logic [PROD_BITS-1:0] r_p1, r_p2;
    t_item                r_s1, r_s2;
    logic [OUT_ABITS:0]   r_out_cnt;
    logic [OUT_ABITS+1:0] in_flight;
    logic                 take;

    assign in_flight = {1'b0, r_out_cnt} + (OUT_ABITS+2)'(r_v1) + (OUT_ABITS+2)'(r_v2);
    assign take      = i_req_valid && (in_flight < (OUT_ABITS+2)'(OUT_DEPTH));
    assign o_req_pop = take;

    always_ff @(posedge i_clk) begin
        r_dx2 <= SQ_DELTA'(i_req.dx) * SQ_DELTA'(i_req.dx);
        r_dy2 <= SQ_DELTA'(i_req.dy) * SQ_DELTA'(i_req.dy);
        r_s1  <= i_req;
        r_p1  <= PROD_BITS'(r_dx2) * PROD_BITS'(r_bb);
        r_p2  <= PROD_BITS'(r_dy2) * PROD_BITS'(r_aa);
        r_s2  <= r_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
        end
    end

    logic [PROD_BITS:0] lhs;
    logic               hit;
    t_pix               res;

    always_comb begin
        lhs    = {1'b0, r_p1} + {1'b0, r_p2};
        hit    = !r_zero && (lhs < (PROD_BITS+1)'(r_ab));
        res.value = hit ? i_fill_color : WHITE_565;
        res.col   = r_s2.col;
        res.row   = r_s2.row;
        res.last  = r_s2.last;
    end

    // result queue
    t_pix r_mem [OUT_DEPTH];
    logic [OUT_ABITS-1:0] r_wr, r_rd;
    logic pop_ok;

    assign o_empty = (r_out_cnt == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_pix   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_mem[r_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_out_cnt <= '0;
        end else begin
            if (r_v2) begin
                r_wr <= r_wr + OUT_ABITS'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + OUT_ABITS'(1);
            end
            if (r_v2 && !pop_ok) begin
                r_out_cnt <= r_out_cnt + (OUT_ABITS+1)'(1);
            end else if (pop_ok && !r_v2) begin
                r_out_cnt <= r_out_cnt - (OUT_ABITS+1)'(1);
            end
        end
    end

endmodule

FILE: sv/ellipse_fill_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_fill_pixel_generator: filled ellipse pixel stream
// Path: a pixel request accepted into the request queue passes through the
//   two multiply stages into the result queue, then to the result ports.
// Throughput: one pixel per cycle from the front-end scan counter, unless full.
// Reset: box registers and fill color clear to 0, the scan returns to (0,0),
//   and both queues empty.
// ----------------------------------------------------------------------------
module ellipse_fill_pixel_generator import efpg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COLOR_BITS-1:0]   i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_restart,
    output logic                    empty,
    input  logic                    pop,
    output logic [COLOR_BITS-1:0]   o_pixel_value,
    output logic [COORD_BITS-1:0]   o_column,
    output logic [COORD_BITS-1:0]   o_row,
    output logic                    o_last_of_area
);

    t_box                  r_box;
    logic [COLOR_BITS-1:0] r_fill_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box        <= '0;
            r_fill_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_LEFT:   r_box.left   <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_TOP:    r_box.top    <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_RIGHT:  r_box.right  <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_BOTTOM: r_box.bottom <= i_cfg_data[COORD_BITS-1:0];
                REG_FILL_COLOR: r_fill_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic  accept;
    t_item front_item;
    logic  q_valid, q_pop;
    t_item q_item;
    t_pix  pix;

    assign accept = push && !full;

    efpg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_box     (r_box),
        .i_accept  (accept),
        .i_restart (i_restart),
        .o_item    (front_item)
    );

    efpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    efpg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_box        (r_box),
        .i_fill_color (r_fill_color),
        .i_req_valid  (q_valid),
        .i_req        (q_item),
        .o_req_pop    (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pix        (pix)
    );

    assign o_pixel_value  = pix.value;
    assign o_column       = pix.col;
    assign o_row          = pix.row;
    assign o_last_of_area = pix.last;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("request queue full after reset");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end took a request from an empty queue");

    a_restart_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_restart |-> front_item.col == r_box.left && front_item.row == r_box.top)
        else $error("restart did not return the scan to the first corner");

endmodule
